@@ sv/mtx_pkg.sv @@
// ----------------------------------------------------------------------------
// mtx_pkg: shared types and codes for the mutex table unit
// Action and status codes, controller states and control structs.
// ----------------------------------------------------------------------------
package mtx_pkg;

    localparam int ActionWidth = 2;
    localparam int IdWidth     = 4;
    localparam int ProcWidth   = 4;
    localparam int StatusWidth = 3;
    localparam int ValueWidth  = 5;

    typedef enum logic [ActionWidth-1:0] {
        ACT_ALLOCATE = 2'd0,
        ACT_DESTROY  = 2'd1,
        ACT_LOCK     = 2'd2,
        ACT_UNLOCK   = 2'd3
    } action_t;

    typedef enum logic [StatusWidth-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_ID     = 3'd1,
        ST_NONE_FREE  = 3'd2,
        ST_OWNED      = 3'd3,
        ST_QUEUE_FULL = 3'd4,
        ST_NOT_LOCKED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture request, start table/queue reads
        logic exec;     // update tables, capture result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;     // result captured in output register
    } dp_stat_t;

endpackage : mtx_pkg

@@ sv/mtx_if.sv @@
// ----------------------------------------------------------------------------
// mtx_req_if / mtx_rsp_if: valid/ready channels of the mutex table unit
// Request channel carries one command; response channel one result.
// ----------------------------------------------------------------------------
interface mtx_req_if;
    logic                               valid;
    logic                               ready;
    logic [mtx_pkg::ActionWidth-1:0]    action;
    logic [mtx_pkg::IdWidth-1:0]        mutex_id;
    logic [mtx_pkg::ProcWidth-1:0]      requester;

    modport source (output valid, action, mutex_id, requester, input ready);
    modport sink   (input valid, action, mutex_id, requester, output ready);
endinterface : mtx_req_if

interface mtx_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [mtx_pkg::StatusWidth-1:0]    status;
    logic [mtx_pkg::ValueWidth-1:0]     value;
    logic                               blocked;
    logic                               wake_valid;
    logic [mtx_pkg::ProcWidth-1:0]      wake_process;

    modport source (output valid, status, value, blocked, wake_valid, wake_process,
                    input ready);
    modport sink   (input valid, status, value, blocked, wake_valid, wake_process,
                    output ready);
endinterface : mtx_rsp_if

@@ sv/mtx_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtx_ctrl: request sequencer
// Accept a request, run read then update cycles, hold result until taken.
// ----------------------------------------------------------------------------
module mtx_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output mtx_pkg::dp_cmd_t    cmd,
    input  mtx_pkg::dp_stat_t   stat
);
    import mtx_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // take a new request in the same cycle the result leaves
                if (out_ready)
                begin
                    state_next = in_valid ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
                cmd.load  = out_ready && in_valid;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid)
        else $error("result not presented after update cycle");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> stat.done)
        else $error("datapath did not capture result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec)
        else $error("accepted request not executed");
endmodule : mtx_ctrl

@@ sv/mtx_dp.sv @@
// ----------------------------------------------------------------------------
// mtx_dp: mutex tables, free list and wait queue memory
// Read one entry on load, read-modify-write it on exec.
// ----------------------------------------------------------------------------
module mtx_dp #(
    parameter int MUTEX_COUNT   = 16,
    parameter int PROCESS_COUNT = 16,
    parameter int WAIT_DEPTH    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mtx_pkg::dp_cmd_t                    cmd,
    output mtx_pkg::dp_stat_t                   stat,
    input  logic [mtx_pkg::ActionWidth-1:0]     action,
    input  logic [mtx_pkg::IdWidth-1:0]         mutex_id,
    input  logic [mtx_pkg::ProcWidth-1:0]       requester,
    output logic [mtx_pkg::StatusWidth-1:0]     status,
    output logic [mtx_pkg::ValueWidth-1:0]      value,
    output logic                                blocked,
    output logic                                wake_valid,
    output logic [mtx_pkg::ProcWidth-1:0]       wake_process
);
    import mtx_pkg::*;

    localparam int MW = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
    localparam int CW = $clog2(MUTEX_COUNT + 1);
    localparam int QW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FW = $clog2(WAIT_DEPTH + 1);
    localparam int LW = $clog2(WAIT_DEPTH + 2);
    localparam int AW = MW + QW;
    localparam int WD = MUTEX_COUNT * (2 ** QW);

    // tables
    logic [MW-1:0]  free_ids_reg  [MUTEX_COUNT];
    logic [MW-1:0]  free_head_reg;
    logic [CW-1:0]  free_count_reg;
    logic           in_use_reg    [MUTEX_COUNT];
    logic           owner_valid_reg [MUTEX_COUNT];
    logic [ProcWidth-1:0] owner_reg [MUTEX_COUNT];
    logic [LW-1:0]  lock_count_reg [MUTEX_COUNT];
    logic [QW-1:0]  wait_head_reg [MUTEX_COUNT];
    logic [FW-1:0]  wait_fill_reg [MUTEX_COUNT];
    logic [ProcWidth-1:0] waiters_mem [WD];

    // request capture
    action_t            act_reg;
    logic [ProcWidth-1:0] req_reg;
    logic               id_ok_reg;
    logic [MW-1:0]      m_reg;
    logic [ProcWidth-1:0] head_proc_reg;
    logic               done_reg;

    logic [MW-1:0] m_in;
    logic [MW-1:0] free_pick;
    logic          in_use_c, own_c;
    logic [LW-1:0] cnt_c;
    logic [QW-1:0] whead_c;
    logic [FW-1:0] wfill_c;
    logic [QW-1:0] tail_slot;
    logic [QW-1:0] head_next;
    logic [MW-1:0] free_tail;

    function automatic logic [QW-1:0] qwrap(input logic [QW:0] x);
        logic [QW:0] r;
        r = (x >= (QW+1)'(WAIT_DEPTH)) ? x - (QW+1)'(WAIT_DEPTH) : x;
        return r[QW-1:0];
    endfunction

    function automatic logic [MW-1:0] mwrap(input logic [MW:0] x);
        logic [MW:0] r;
        r = (x >= (MW+1)'(MUTEX_COUNT)) ? x - (MW+1)'(MUTEX_COUNT) : x;
        return r[MW-1:0];
    endfunction

    assign m_in      = MW'(mutex_id);
    assign in_use_c  = in_use_reg[m_reg];
    assign own_c     = owner_valid_reg[m_reg];
    assign cnt_c     = lock_count_reg[m_reg];
    assign whead_c   = wait_head_reg[m_reg];
    assign wfill_c   = wait_fill_reg[m_reg];
    assign free_pick = free_ids_reg[free_head_reg];
    assign tail_slot = (WAIT_DEPTH > 1) ?
                       qwrap({1'b0, whead_c} + (QW+1)'(wfill_c)) : '0;
    assign head_next = (WAIT_DEPTH > 1) ? qwrap({1'b0, whead_c} + (QW+1)'(1)) : '0;
    assign free_tail = mwrap({1'b0, free_head_reg} + (MW+1)'(free_count_reg));

    // load: capture request and read head waiter of addressed queue
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg       <= action_t'(action);
            req_reg       <= requester;
            id_ok_reg     <= (32'(mutex_id) < MUTEX_COUNT);
            m_reg         <= m_in;
            head_proc_reg <= waiters_mem[{m_in, wait_head_reg[m_in]}];
        end
    end

    // waiter memory: single write port on exec
    always_ff @(posedge clk)
    begin
        if (cmd.exec && act_reg == ACT_LOCK && id_ok_reg && in_use_c && own_c
            && 32'(req_reg) < PROCESS_COUNT && 32'(wfill_c) < WAIT_DEPTH)
        begin
            waiters_mem[AW'({m_reg, tail_slot})] <= req_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && act_reg == ACT_LOCK && id_ok_reg && in_use_c && !own_c
            && 32'(req_reg) < PROCESS_COUNT)
        begin
            owner_reg[m_reg] <= req_reg;
        end
        else if (cmd.exec && act_reg == ACT_UNLOCK && id_ok_reg && in_use_c
                 && cnt_c > 1 && wfill_c != 0)
        begin
            owner_reg[m_reg] <= head_proc_reg;
        end
    end

    // control tables and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MUTEX_COUNT; i++)
            begin
                free_ids_reg[i]    <= MW'(i);
                in_use_reg[i]      <= 1'b0;
                owner_valid_reg[i] <= 1'b0;
                lock_count_reg[i]  <= '0;
                wait_head_reg[i]   <= '0;
                wait_fill_reg[i]   <= '0;
            end
            free_head_reg  <= '0;
            free_count_reg <= CW'(MUTEX_COUNT);
            done_reg       <= 1'b0;
            status         <= ST_OK;
            value          <= '0;
            blocked        <= 1'b0;
            wake_valid     <= 1'b0;
            wake_process   <= '0;
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.exec)
            begin
                status       <= ST_OK;
                value        <= '0;
                blocked      <= 1'b0;
                wake_valid   <= 1'b0;
                wake_process <= '0;
                priority if (act_reg == ACT_ALLOCATE)
                begin
                    if (free_count_reg == 0)
                    begin
                        status <= ST_NONE_FREE;
                    end
                    else
                    begin
                        free_head_reg  <= mwrap({1'b0, free_head_reg} + (MW+1)'(1));
                        free_count_reg <= free_count_reg - 1'b1;
                        in_use_reg[free_pick]      <= 1'b1;
                        owner_valid_reg[free_pick] <= 1'b0;
                        lock_count_reg[free_pick]  <= '0;
                        wait_head_reg[free_pick]   <= '0;
                        wait_fill_reg[free_pick]   <= '0;
                        value <= ValueWidth'(free_pick);
                    end
                end
                else if (!id_ok_reg || !in_use_c)
                begin
                    status <= ST_BAD_ID;
                end
                else if (act_reg == ACT_DESTROY)
                begin
                    if (own_c)
                    begin
                        status <= ST_OWNED;
                        value  <= ValueWidth'(cnt_c);
                    end
                    else
                    begin
                        free_ids_reg[free_tail] <= m_reg;
                        free_count_reg <= free_count_reg + 1'b1;
                        in_use_reg[m_reg]      <= 1'b0;
                        lock_count_reg[m_reg]  <= '0;
                        wait_head_reg[m_reg]   <= '0;
                        wait_fill_reg[m_reg]   <= '0;
                    end
                end
                else if (act_reg == ACT_LOCK)
                begin
                    if (32'(req_reg) >= PROCESS_COUNT)
                    begin
                        status <= ST_BAD_ID;
                    end
                    else if (own_c)
                    begin
                        if (32'(wfill_c) >= WAIT_DEPTH)
                        begin
                            status <= ST_QUEUE_FULL;
                            value  <= ValueWidth'(cnt_c);
                        end
                        else
                        begin
                            wait_fill_reg[m_reg]  <= wfill_c + 1'b1;
                            lock_count_reg[m_reg] <= cnt_c + 1'b1;
                            value   <= ValueWidth'(cnt_c + 1'b1);
                            blocked <= 1'b1;
                        end
                    end
                    else
                    begin
                        owner_valid_reg[m_reg] <= 1'b1;
                        lock_count_reg[m_reg]  <= cnt_c + 1'b1;
                        value <= ValueWidth'(cnt_c + 1'b1);
                    end
                end
                else
                begin
                    if (cnt_c == 0)
                    begin
                        status <= ST_NOT_LOCKED;
                    end
                    else
                    begin
                        lock_count_reg[m_reg] <= cnt_c - 1'b1;
                        value <= ValueWidth'(cnt_c - 1'b1);
                        if (cnt_c == 1 || wfill_c == 0)
                        begin
                            owner_valid_reg[m_reg] <= 1'b0;
                        end
                        else
                        begin
                            wait_head_reg[m_reg] <= head_next;
                            wait_fill_reg[m_reg] <= wfill_c - 1'b1;
                            wake_valid   <= 1'b1;
                            wake_process <= head_proc_reg;
                        end
                    end
                end
            end
        end
    end

    assign stat.done = done_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_count_reg) <= MUTEX_COUNT)
        else $error("free list overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.done && wake_valid |-> !blocked)
        else $error("wake and block in one result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && act_reg == ACT_ALLOCATE && free_count_reg != 0)
        |=> free_count_reg == $past(free_count_reg) - 1'b1)
        else $error("allocate did not consume a free id");
endmodule : mtx_dp

@@ sv/mutex_table_with_wait_queues_unit.sv @@
// ----------------------------------------------------------------------------
// mutex_table_with_wait_queues_unit: mutex table with FIFO wait queues
// Allocate, destroy, lock and unlock mutexes; queue and wake waiters.
// ----------------------------------------------------------------------------
// Each request is first captured, with the head waiter of the addressed
// queue read from the waiter memory; then the mutex entry, the free list
// and the queue tail are read-modify-written. A new request is taken in
// the cycle its predecessor's result transfers, and not before. After
// reset the free list holds every mutex id in order and no clearing pass
// is needed.
module mutex_table_with_wait_queues_unit #(
    parameter int MUTEX_COUNT   = 16,
    parameter int PROCESS_COUNT = 16,
    parameter int WAIT_DEPTH    = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    mtx_req_if.sink req,
    mtx_rsp_if.source rsp
);
    import mtx_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequence each request through capture and update
    mtx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // hold the tables and produce the result register
    mtx_dp #(
        .MUTEX_COUNT   (MUTEX_COUNT),
        .PROCESS_COUNT (PROCESS_COUNT),
        .WAIT_DEPTH    (WAIT_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (req.action),
        .mutex_id     (req.mutex_id),
        .requester    (req.requester),
        .status       (rsp.status),
        .value        (rsp.value),
        .blocked      (rsp.blocked),
        .wake_valid   (rsp.wake_valid),
        .wake_process (rsp.wake_process)
    );
endmodule : mutex_table_with_wait_queues_unit
